// ===== hw/rtl/scr_pkg.sv =====
`timescale 1ns / 1ps

package scr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PAGE_NUM_W = 16;
    localparam int FRAME_IDX_W = 3;
    localparam int COUNT_W    = 32;
    localparam int CFG_W      = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_RESOLVE,
        S_SWEEP
    } state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic start_sweep;
        logic clear_ref;
        logic place;
        logic hit_done;
    } cmd_t;

    typedef struct packed {
        logic any_hit;
        logic ref_at_hand;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/scr_req_if.sv =====
`timescale 1ns / 1ps

interface scr_req_if
    import scr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PAGE_NUM_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

// ===== hw/rtl/scr_rsp_if.sv =====
`timescale 1ns / 1ps

interface scr_rsp_if
    import scr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [COUNT_W-1:0]     request_count;
    logic [COUNT_W-1:0]     fault_count;

    modport source (output valid, output hit, output frame_index,
                    output request_count, output fault_count, input ready);
    modport sink (input valid, input hit, input frame_index,
                  input request_count, input fault_count, output ready);
endinterface

// ===== hw/rtl/scr_ctrl.sv =====
`timescale 1ns / 1ps

module scr_ctrl
    import scr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (sts.any_hit)
                begin
                    // hold until the output slot frees up
                    if (sts.out_free)
                    begin
                        cmd.hit_done = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.start_sweep = 1'b1;
                    state_next      = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (sts.ref_at_hand)
                begin
                    cmd.clear_ref = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/scr_dp.sv =====
`timescale 1ns / 1ps

module scr_dp
    import scr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic [PAGE_NUM_W-1:0]  page_number,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_hit,
    output logic [FRAME_IDX_W-1:0] out_frame_index,
    output logic [COUNT_W-1:0]     out_request_count,
    output logic [COUNT_W-1:0]     out_fault_count
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int EXT_W = (IDX_W > FRAME_IDX_W) ? IDX_W : FRAME_IDX_W;
    localparam int CMP_W = 8;

    logic [PAGE_BITS-1:0] frame_page [FRAMES];

    logic [CFG_W-1:0]     active_frames_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [FRAMES-1:0]    match_reg;
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    ref_reg;
    logic [IDX_W-1:0]     hand_reg;
    logic [IDX_W-1:0]     sweep_reg;
    logic [COUNT_W-1:0]   req_cnt_reg;
    logic [COUNT_W-1:0]   flt_cnt_reg;

    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [FRAME_IDX_W-1:0] out_idx_reg;
    logic [COUNT_W-1:0]     out_req_reg;
    logic [COUNT_W-1:0]     out_flt_reg;

    logic [CNT_W-1:0]   n_next;
    logic [FRAMES-1:0]  match_next;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   sweep_start;
    logic [IDX_W-1:0]   sweep_adv;
    logic [CNT_W-1:0]   sweep_inc;
    logic [COUNT_W-1:0] req_inc;
    logic [COUNT_W-1:0] flt_inc;
    logic [EXT_W-1:0]   hit_ext;
    logic [EXT_W-1:0]   sweep_ext;

    // clamp the frames-in-use setting to 1..FRAMES
    always_comb
    begin
        if (active_frames_reg == '0)
        begin
            n_next = CNT_W'(1);
        end
        else if (CMP_W'(active_frames_reg) > CMP_W'(FRAMES))
        begin
            n_next = CNT_W'(FRAMES);
        end
        else
        begin
            n_next = CNT_W'(active_frames_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            match_next[i] = valid_reg[i] && (frame_page[i] == page_reg)
                            && (CNT_W'(i) < n_reg);
        end
    end

    // lowest matching frame wins
    always_comb
    begin
        hit_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign sweep_start = (CNT_W'(hand_reg) >= n_reg) ? '0 : hand_reg;
    assign sweep_inc   = CNT_W'(sweep_reg) + CNT_W'(1);
    assign sweep_adv   = (sweep_inc < n_reg) ? IDX_W'(sweep_inc) : '0;

    assign req_inc = (req_cnt_reg == COUNT_MAX) ? req_cnt_reg : req_cnt_reg + 1'b1;
    assign flt_inc = (flt_cnt_reg == COUNT_MAX) ? flt_cnt_reg : flt_cnt_reg + 1'b1;

    assign hit_ext   = EXT_W'(hit_idx);
    assign sweep_ext = EXT_W'(sweep_reg);

    assign sts.any_hit     = |match_reg;
    assign sts.ref_at_hand = ref_reg[sweep_reg];
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.place)
        begin
            frame_page[sweep_reg] <= page_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= PAGE_BITS'(page_number);
            n_reg    <= n_next;
        end
        if (cmd.match)
        begin
            match_reg <= match_next;
        end
        if (cmd.start_sweep)
        begin
            sweep_reg <= sweep_start;
        end
        else if (cmd.clear_ref)
        begin
            sweep_reg <= sweep_adv;
        end
        if (cmd.hit_done)
        begin
            out_hit_reg <= 1'b1;
            out_idx_reg <= hit_ext[FRAME_IDX_W-1:0];
            out_req_reg <= req_inc;
            out_flt_reg <= flt_cnt_reg;
        end
        else if (cmd.place)
        begin
            out_hit_reg <= 1'b0;
            out_idx_reg <= sweep_ext[FRAME_IDX_W-1:0];
            out_req_reg <= req_inc;
            out_flt_reg <= flt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_frames_reg <= CFG_W'(FRAMES);
            valid_reg         <= '0;
            ref_reg           <= '0;
            hand_reg          <= '0;
            req_cnt_reg       <= '0;
            flt_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_frames_reg <= cfg_wdata;
            end
            if (cmd.hit_done)
            begin
                ref_reg[hit_idx] <= 1'b1;
                req_cnt_reg      <= req_inc;
            end
            if (cmd.clear_ref)
            begin
                ref_reg[sweep_reg] <= 1'b0;
            end
            if (cmd.place)
            begin
                valid_reg[sweep_reg] <= 1'b1;
                ref_reg[sweep_reg]   <= 1'b0;
                hand_reg             <= sweep_adv;
                req_cnt_reg          <= req_inc;
                flt_cnt_reg          <= flt_inc;
            end
            if (cmd.hit_done || cmd.place)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_hit           = out_hit_reg;
    assign out_frame_index   = out_idx_reg;
    assign out_request_count = out_req_reg;
    assign out_fault_count   = out_flt_reg;

endmodule

// ===== hw/rtl/second_chance_page_replacer.sv =====
`timescale 1ns / 1ps

// Second-chance (clock) page replacer.
// req carries one page number per beat; rsp returns one beat per request with
// hit, the frame used, and the saturating request and fault totals.
// cfg_we/cfg_wdata set the number of frames in use; write only while idle.
// One request is worked at a time. A hit is answered after the request is
// loaded, a parallel tag compare is registered, then a priority select.
// On a miss the hand sweeps, clearing set reference bits (0..frames in use)
// one frame per cycle, then places the page in the first clear frame.
// req.ready rises again in the cycle the result is registered, so the next
// request can be taken while a finished result still waits on rsp.
// If the receiver stalls, the result holds in the output register and the
// block holds the following request just before it would write its result.
// Reset clears all valid and reference bits, the hand and both totals, and
// sets the frames in use to FRAMES; page tags need no clearing.
module second_chance_page_replacer
    import scr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    scr_req_if.sink          req,
    scr_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    scr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    scr_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .page_number       (req.page_number),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_hit           (rsp.hit),
        .out_frame_index   (rsp.frame_index),
        .out_request_count (rsp.request_count),
        .out_fault_count   (rsp.fault_count)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import scr_pkg::*;
();

    localparam int NUM_FRAMES      = FRAMES_DEF;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 11;
    localparam int PAGES_PER_PHASE = 58;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame;
        logic [COUNT_W-1:0]     requests;
        logic [COUNT_W-1:0]     faults;
    } page_result_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_BLOCKS,
        RX_LIGHT
    } rx_pattern_t;

    class replacer_tracker;
        logic [PAGE_NUM_W-1:0] frame_page [NUM_FRAMES];
        bit                    frame_valid [NUM_FRAMES];
        bit                    ref_bit [NUM_FRAMES];
        int unsigned           hand;
        logic [COUNT_W-1:0]    requests_total;
        logic [COUNT_W-1:0]    faults_total;
        logic [CFG_W-1:0]      frames_setting;
        page_result_t          pending_results[$];
        int                    errors;
        int                    reported;
        int                    hits_predicted;
        int                    faults_predicted;
        int                    results_checked;

        function new();
            int i;
            for (i = 0; i < NUM_FRAMES; i++)
            begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
                ref_bit[i]     = 1'b0;
            end
            hand             = 0;
            requests_total   = '0;
            faults_total     = '0;
            frames_setting   = CFG_W'(NUM_FRAMES);
            errors           = 0;
            reported         = 0;
            hits_predicted   = 0;
            faults_predicted = 0;
            results_checked  = 0;
        endfunction

        function int unsigned frames_in_use();
            if (frames_setting == 0)
                return 1;
            if (frames_setting > NUM_FRAMES)
                return NUM_FRAMES;
            return 32'(frames_setting);
        endfunction

        function void predict_request(logic [PAGE_NUM_W-1:0] page);
            page_result_t res;
            int unsigned  n;
            int unsigned  h;
            int unsigned  used;
            int           i;
            bit           found;
            n     = frames_in_use();
            found = 1'b0;
            used  = 0;
            if (requests_total != COUNT_MAX)
                requests_total++;
            // lowest matching frame in use wins
            for (i = 0; i < n; i++)
            begin
                if (!found && frame_valid[i] && frame_page[i] == page)
                begin
                    found      = 1'b1;
                    ref_bit[i] = 1'b1;
                    used       = i;
                end
            end
            if (found)
                hits_predicted++;
            else
            begin
                faults_predicted++;
                if (faults_total != COUNT_MAX)
                    faults_total++;
                h = (hand >= n) ? 0 : hand;
                // clear set bits and advance until a clear frame turns up
                while (ref_bit[h])
                begin
                    ref_bit[h] = 1'b0;
                    h = (h + 1 < n) ? h + 1 : 0;
                end
                frame_page[h]  = page;
                frame_valid[h] = 1'b1;
                ref_bit[h]     = 1'b0;
                used           = h;
                hand           = (h + 1 < n) ? h + 1 : 0;
            end
            res.hit      = found;
            res.frame    = FRAME_IDX_W'(used);
            res.requests = requests_total;
            res.faults   = faults_total;
            pending_results.push_back(res);
        endfunction

        function void check_result(page_result_t got);
            page_result_t want;
            bit           bad;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("unexpected result beat: hit=%0d frame=%0d req=%0d flt=%0d",
                             got.hit, got.frame, got.requests, got.faults);
                end
                return;
            end
            want = pending_results.pop_front();
            bad  = 1'b0;
            if (got.hit !== want.hit)
                bad = 1'b1;
            if (got.frame !== want.frame)
                bad = 1'b1;
            if (got.requests !== want.requests)
                bad = 1'b1;
            if (got.faults !== want.faults)
                bad = 1'b1;
            if (bad)
            begin
                errors++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("mismatch on result %0d: expected hit=%0d frame=%0d req=%0d flt=%0d",
                             results_checked, want.hit, want.frame, want.requests,
                             want.faults);
                    $display("                      actual hit=%0d frame=%0d req=%0d flt=%0d",
                             got.hit, got.frame, got.requests, got.faults);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    scr_req_if req_if ();
    scr_rsp_if rsp_if ();

    replacer_tracker tracker = new();

    logic [CFG_W-1:0] setting_plan [8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6, 4'd9, 4'd2};
    int               settings_used;
    int               idle_cycles;

    second_chance_page_replacer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_page(input logic [PAGE_NUM_W-1:0] page);
        req_if.valid       <= 1'b1;
        req_if.page_number <= page;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        tracker.predict_request(page);
    endtask

    task automatic run_pages(input logic [PAGE_NUM_W-1:0] pages[$]);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 12);
        foreach (pages[k])
        begin
            send_page(pages[k]);
            burst_left--;
            if (burst_left == 0 && k != pages.size() - 1)
            begin
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    req_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
        end
        req_if.valid <= 1'b0;
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        // drain: the register may change only while the block is idle
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.frames_setting = value;
        settings_used++;
    endtask

    // receiver: pick a new stall pattern at random whenever the current one runs out
    initial
    begin
        rx_pattern_t pattern;
        int          pattern_left;
        int          run_left;
        bit          level;
        pattern      = RX_OPEN;
        pattern_left = 0;
        run_left     = 0;
        level        = 1'b1;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pattern_left == 0)
            begin
                pattern      = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(40, 300);
            end
            pattern_left--;
            case (pattern)
                RX_OPEN:  rsp_if.ready <= 1'b1;
                RX_COIN:  rsp_if.ready <= 1'($urandom_range(0, 1));
                RX_BLOCKS:
                begin
                    if (run_left == 0)
                    begin
                        level    = !level;
                        run_left = level ? $urandom_range(1, 4) : $urandom_range(1, 8);
                    end
                    run_left--;
                    rsp_if.ready <= level;
                end
                default:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            tracker.check_result({rsp_if.hit, rsp_if.frame_index,
                                  rsp_if.request_count, rsp_if.fault_count});
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, tracker.pending_results.size());
                $display("second_chance_page_replacer regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [PAGE_NUM_W-1:0] pages[$];
        logic [PAGE_NUM_W-1:0] pool[$];
        logic [CFG_W-1:0]      setting;
        int unsigned           n;
        int                    pool_size;
        int                    p;
        int                    j;
        settings_used      = 0;
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.page_number <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill all frames from empty, two hits, then sweep past set bits
        pages = '{16'h0000, 16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF, 16'hA5A5,
                  16'h5A5A, 16'h0F0F, 16'hF0F0, 16'h1111, 16'h8888, 16'h2222};
        run_pages(pages);

        // shrink below the hand; a page parked beyond the frames in use misses
        write_frames(4'd2);
        pages = '{16'h5A5A, 16'h5A5A, 16'h0F0F};
        run_pages(pages);

        // zero frames acts as one frame
        write_frames(4'd0);
        pages = '{16'h0F0F, 16'h0F0F, 16'h3C3C};
        run_pages(pages);

        // oversize setting acts as all frames; duplicate page resolves low
        write_frames(4'd15);
        pages = '{16'h0F0F, 16'hF0F0};
        run_pages(pages);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            setting = (p < 8) ? setting_plan[p] : CFG_W'($urandom_range(0, 15));
            write_frames(setting);
            n         = tracker.frames_in_use();
            pool_size = $urandom_range(1, 2 * n + 2);
            pool.delete();
            for (j = 0; j < pool_size; j++)
                pool.push_back(PAGE_NUM_W'($urandom));
            pages.delete();
            // mostly a small working set so hits and sweeps happen often
            for (j = 0; j < PAGES_PER_PHASE; j++)
            begin
                if ($urandom_range(0, 99) < 85)
                    pages.push_back(pool[$urandom_range(0, pool_size - 1)]);
                else
                    pages.push_back(PAGE_NUM_W'($urandom));
            end
            run_pages(pages);
        end

        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d hits, %0d faults) across %0d frame settings",
                 tracker.hits_predicted + tracker.faults_predicted,
                 tracker.hits_predicted, tracker.faults_predicted, settings_used);
        $display("checked %0d result beats, %0d errors",
                 tracker.results_checked, tracker.errors);
        if (tracker.errors == 0)
            $display("second_chance_page_replacer regression: pass");
        else
            $display("second_chance_page_replacer regression: fail");
        $finish;
    end

endmodule
